// ===== design/hmmfs_pkg.sv =====
// hmmfs_pkg: sizes, opcodes and shared structs of the scaled hmm forward block
// used by hmmfs_cell and hmm_forward_scaled_top; no dependencies
package hmmfs_pkg;

  localparam int NUM_STATES  = 8;
  localparam int NUM_SYMBOLS = 16;
  localparam int LOG_N       = $clog2(NUM_STATES);
  localparam int LOG_SYM     = $clog2(NUM_SYMBOLS);
  localparam int PROB_W      = 16;
  localparam int COL_W       = 8;
  localparam int ROW_W       = 6;
  localparam int QUO_W       = 16;
  localparam logic [PROB_W-1:0] ONE_Q15 = 16'd32768;

  // accumulator holds up to NUM_STATES * 2^30
  localparam int ACC_W = 31 + LOG_N;
  localparam int P_W   = ACC_W - 15;
  localparam int U_W   = P_W;
  localparam int S_W   = U_W + LOG_N;
  localparam int REM_W = S_W + 1;
  localparam int CNT_W = (LOG_N > 4) ? LOG_N : 4;

  typedef enum logic [1:0] {
    OP_LOAD_TRANS = 2'd0,
    OP_LOAD_EMIT  = 2'd1,
    OP_LOAD_INIT  = 2'd2,
    OP_OBSERVE    = 2'd3
  } op_e;

  // sequencing controls broadcast to every cell
  typedef struct packed {
    logic               clear;
    logic               mac;
    logic               mul;
    logic               rot_u;
    logic               div;
    logic               div_first;
    logic               div_last;
    logic               first;
    logic               sym_ok;
    logic [LOG_SYM-1:0] sym;
    logic [S_W-1:0]     scale;
    logic               scale_zero;
  } ctrl_t;

  // table load word broadcast to every cell
  typedef struct packed {
    logic              trans_we;
    logic              emit_we;
    logic              init_we;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [PROB_W-1:0] val;
  } ld_t;

endpackage

// ===== design/hmmfs_cell.sv =====
// hmmfs_cell: one state of the forward pass, with its transition column,
// emission row, initial entry, alpha and serial divider; uses hmmfs_pkg
module hmmfs_cell (
  input  logic                          clk_i,
  input  logic [hmmfs_pkg::LOG_N-1:0]   cell_id_i,
  input  hmmfs_pkg::ctrl_t              ctrl_i,
  input  hmmfs_pkg::ld_t                ld_i,
  input  logic [hmmfs_pkg::PROB_W-1:0]  alpha_nb_i,
  input  logic [hmmfs_pkg::U_W-1:0]     u_nb_i,
  output logic [hmmfs_pkg::PROB_W-1:0]  alpha_o,
  output logic [hmmfs_pkg::U_W-1:0]     u_o
);

  logic [hmmfs_pkg::PROB_W-1:0] trans_q [hmmfs_pkg::NUM_STATES];
  logic [hmmfs_pkg::PROB_W-1:0] emit_q  [hmmfs_pkg::NUM_SYMBOLS];
  logic [hmmfs_pkg::PROB_W-1:0] init_q;
  logic [hmmfs_pkg::PROB_W-1:0] alpha_q;
  logic [hmmfs_pkg::U_W-1:0]    u_q;
  logic [hmmfs_pkg::ACC_W-1:0]  acc_q;
  logic [hmmfs_pkg::LOG_N-1:0]  idx_q;
  logic [hmmfs_pkg::REM_W-1:0]  rem_q;
  logic [hmmfs_pkg::QUO_W-1:0]  quo_q;

  logic [2*hmmfs_pkg::PROB_W-1:0]       prod;
  logic [hmmfs_pkg::P_W-1:0]            p_sel;
  logic [hmmfs_pkg::PROB_W-1:0]         e_sel;
  logic [hmmfs_pkg::P_W+hmmfs_pkg::PROB_W-1:0] pe;
  logic [hmmfs_pkg::REM_W-1:0]          cur;
  logic                                 ge;
  logic [hmmfs_pkg::REM_W-1:0]          rem_d;
  logic [hmmfs_pkg::QUO_W-1:0]          quo_d;
  logic [hmmfs_pkg::LOG_N-1:0]          idx_d;

  // multiply-accumulate operand: alpha held in the cell, rotated in from the neighbor each step, times transition entry
  assign prod = {16'd0, alpha_q} * {16'd0, trans_q[idx_q]};
  assign idx_d = (idx_q == hmmfs_pkg::LOG_N'(hmmfs_pkg::NUM_STATES - 1))
               ? '0 : idx_q + 1'b1;

  // emission step
  assign p_sel = ctrl_i.first ? hmmfs_pkg::P_W'(init_q)
                              : acc_q[hmmfs_pkg::ACC_W-1:15];
  assign e_sel = ctrl_i.sym_ok ? emit_q[ctrl_i.sym] : '0;
  assign pe    = {{hmmfs_pkg::PROB_W{1'b0}}, p_sel}
               * {{hmmfs_pkg::P_W{1'b0}}, e_sel};

  // restoring divider, one quotient bit per cycle
  assign cur   = ctrl_i.div_first ? hmmfs_pkg::REM_W'(u_q)
                                  : {rem_q[hmmfs_pkg::REM_W-2:0], 1'b0};
  assign ge    = cur >= hmmfs_pkg::REM_W'(ctrl_i.scale);
  assign rem_d = ge ? cur - hmmfs_pkg::REM_W'(ctrl_i.scale) : cur;
  assign quo_d = {quo_q[hmmfs_pkg::QUO_W-2:0], ge};

  // table loads
  always_ff @(posedge clk_i) begin
    if (ld_i.trans_we && ld_i.col[hmmfs_pkg::LOG_N-1:0] == cell_id_i) begin
      trans_q[ld_i.row[hmmfs_pkg::LOG_N-1:0]] <= ld_i.val;
    end
    if (ld_i.emit_we && ld_i.row[hmmfs_pkg::LOG_N-1:0] == cell_id_i) begin
      emit_q[ld_i.col[hmmfs_pkg::LOG_SYM-1:0]] <= ld_i.val;
    end
    if (ld_i.init_we && ld_i.row[hmmfs_pkg::LOG_N-1:0] == cell_id_i) begin
      init_q <= ld_i.val;
    end
  end

  // datapath: accumulate, rotate, multiply, divide
  always_ff @(posedge clk_i) begin
    if (ctrl_i.clear) begin
      acc_q <= '0;
      idx_q <= cell_id_i;
    end else if (ctrl_i.mac) begin
      acc_q   <= acc_q + hmmfs_pkg::ACC_W'(prod);
      idx_q   <= idx_d;
      alpha_q <= alpha_nb_i;
    end
    if (ctrl_i.mul) begin
      u_q <= pe[hmmfs_pkg::U_W+14:15];
    end else if (ctrl_i.rot_u) begin
      u_q <= u_nb_i;
    end
    if (ctrl_i.div) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
    if (ctrl_i.div_last) begin
      alpha_q <= ctrl_i.scale_zero ? '0 : quo_d;
    end
  end

  assign alpha_o = alpha_q;
  assign u_o     = u_q;

endmodule

// ===== design/hmm_forward_scaled_top.sv =====
// hmm_forward_scaled_top: sequencer, ring of state cells and result port
// depends on hmmfs_pkg and hmmfs_cell
//
// Load words (ops 0..2) write a table entry in the cycle they are taken and
// keep busy low. An observe word runs multiply-accumulate around the cell
// ring, one emission multiply, the scale sum, the bit-serial divide in each
// cell and the result output, in that order. Results come one per cycle on
// valid_o and must be taken as they appear; the receiver cannot stall.
module hmm_forward_scaled_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op_i,
  input  logic [5:0]  row_state_i,
  input  logic [7:0]  column_index_i,
  input  logic [15:0] prob_value_i,
  input  logic [7:0]  symbol_i,
  input  logic        first_obs_i,
  output logic        valid_o,
  output logic [5:0]  state_index_o,
  output logic [15:0] alpha_value_o,
  output logic [15:0] scale_value_o,
  output logic        scale_zero_o,
  output logic        last_result_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_MAC, S_MUL, S_SUM, S_DIV, S_OUT
  } state_e;

  state_e                          state_q;
  logic [hmmfs_pkg::CNT_W-1:0]     cnt_q;
  logic                            first_q;
  logic                            sym_ok_q;
  logic [hmmfs_pkg::LOG_SYM-1:0]   sym_q;
  logic [hmmfs_pkg::S_W-1:0]       scale_q;

  logic                            accept;
  logic                            obs_acc;
  logic                            cnt_last_n;
  logic                            cnt_last_div;
  logic [hmmfs_pkg::PROB_W-1:0]    prob_sat;
  hmmfs_pkg::ctrl_t                ctrl;
  hmmfs_pkg::ld_t                  ld;

  logic [hmmfs_pkg::PROB_W-1:0] alpha_w [hmmfs_pkg::NUM_STATES];
  logic [hmmfs_pkg::U_W-1:0]    u_w     [hmmfs_pkg::NUM_STATES];

  assign busy    = (state_q != S_IDLE);
  assign accept  = start && !busy;
  assign obs_acc = accept && (op_i == hmmfs_pkg::OP_OBSERVE);
  assign cnt_last_n = (cnt_q == hmmfs_pkg::CNT_W'(hmmfs_pkg::NUM_STATES - 1));
  assign cnt_last_div = (cnt_q == hmmfs_pkg::CNT_W'(hmmfs_pkg::QUO_W - 1));

  // load decode with range checks and saturation
  assign prob_sat = (prob_value_i > hmmfs_pkg::ONE_Q15) ? hmmfs_pkg::ONE_Q15
                                                       : prob_value_i;
  always_comb begin
    ld.row = row_state_i;
    ld.col = column_index_i;
    ld.val = prob_sat;
    ld.trans_we = accept && (op_i == hmmfs_pkg::OP_LOAD_TRANS)
                  && ({1'b0, row_state_i} < 7'(hmmfs_pkg::NUM_STATES))
                  && ({1'b0, column_index_i} < 9'(hmmfs_pkg::NUM_STATES));
    ld.emit_we  = accept && (op_i == hmmfs_pkg::OP_LOAD_EMIT)
                  && ({1'b0, row_state_i} < 7'(hmmfs_pkg::NUM_STATES))
                  && ({1'b0, column_index_i} < 9'(hmmfs_pkg::NUM_SYMBOLS));
    ld.init_we  = accept && (op_i == hmmfs_pkg::OP_LOAD_INIT)
                  && ({1'b0, row_state_i} < 7'(hmmfs_pkg::NUM_STATES));
  end

  // cell controls
  always_comb begin
    ctrl.clear      = obs_acc;
    ctrl.mac        = (state_q == S_MAC);
    ctrl.mul        = (state_q == S_MUL);
    ctrl.rot_u      = (state_q == S_SUM);
    ctrl.div        = (state_q == S_DIV);
    ctrl.div_first  = (state_q == S_DIV) && (cnt_q == '0);
    ctrl.div_last   = (state_q == S_DIV) && cnt_last_div;
    ctrl.first      = first_q;
    ctrl.sym_ok     = sym_ok_q;
    ctrl.sym        = sym_q;
    ctrl.scale      = scale_q;
    ctrl.scale_zero = (scale_q == '0);
  end

  // ring of cells, each fed by its upper neighbor
  for (genvar g = 0; g < hmmfs_pkg::NUM_STATES; g++) begin : g_cell
    hmmfs_cell u_cell (
      .clk_i      (clk_i),
      .cell_id_i  (hmmfs_pkg::LOG_N'(g)),
      .ctrl_i     (ctrl),
      .ld_i       (ld),
      .alpha_nb_i (alpha_w[(g + 1) % hmmfs_pkg::NUM_STATES]),
      .u_nb_i     (u_w[(g + 1) % hmmfs_pkg::NUM_STATES]),
      .alpha_o    (alpha_w[g]),
      .u_o        (u_w[g])
    );
  end

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      cnt_q         <= '0;
      first_q       <= 1'b0;
      sym_ok_q      <= 1'b0;
      sym_q         <= '0;
      scale_q       <= '0;
      valid_o       <= 1'b0;
      state_index_o <= '0;
      alpha_value_o <= '0;
      scale_value_o <= '0;
      scale_zero_o  <= 1'b0;
      last_result_o <= 1'b0;
    end else begin
      valid_o       <= (state_q == S_OUT);
      last_result_o <= (state_q == S_OUT) && cnt_last_n;
      unique case (state_q)
        S_IDLE: begin
          if (obs_acc) begin
            state_q  <= S_MAC;
            cnt_q    <= '0;
            first_q  <= first_obs_i;
            sym_ok_q <= ({1'b0, symbol_i} < 9'(hmmfs_pkg::NUM_SYMBOLS));
            sym_q    <= symbol_i[hmmfs_pkg::LOG_SYM-1:0];
            scale_q  <= '0;
          end
        end
        S_MAC: begin
          cnt_q <= cnt_last_n ? '0 : cnt_q + 1'b1;
          if (cnt_last_n) begin
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          state_q <= S_SUM;
        end
        S_SUM: begin
          scale_q <= scale_q + hmmfs_pkg::S_W'(u_w[0]);
          cnt_q   <= cnt_last_n ? '0 : cnt_q + 1'b1;
          if (cnt_last_n) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          cnt_q <= cnt_last_div ? '0 : cnt_q + 1'b1;
          if (cnt_last_div) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          state_index_o <= 6'(cnt_q);
          alpha_value_o <= alpha_w[cnt_q[hmmfs_pkg::LOG_N-1:0]];
          scale_value_o <= (scale_q > hmmfs_pkg::S_W'(hmmfs_pkg::ONE_Q15))
                         ? hmmfs_pkg::ONE_Q15 : scale_q[15:0];
          scale_zero_o  <= (scale_q == '0);
          cnt_q         <= cnt_last_n ? '0 : cnt_q + 1'b1;
          if (cnt_last_n) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // zero scale means every alpha is zero
  a_zero_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && scale_zero_o |-> alpha_value_o == '0)
    else $error("alpha nonzero with zero scale");

  // the last word is always a strobed word
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_result_o |-> valid_o)
    else $error("last without valid");

  // results of one observation come back to back
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_result_o |=> valid_o)
    else $error("gap in result burst");

  // normalized alpha never exceeds one
  a_alpha_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> alpha_value_o <= hmmfs_pkg::ONE_Q15)
    else $error("alpha above one");

endmodule
